@@ hdl/ddo_pkg.sv @@
// Package for the differential drive odometry block: payload structs, widths,
// arithmetic constants, register indexes, sequencer states and the CORDIC table.
// Depends on nothing; used by ddo_div and differential_drive_odometry.
package ddo_pkg;

   // Field and datapath widths
   localparam int RPM_W     = 16;
   localparam int US_W      = 16;
   localparam int DATA_W    = 32;
   localparam int RADIUS_W  = 19;
   localparam int BASE_W    = 25;
   localparam int MUL_A_W   = 36;
   localparam int MUL_B_W   = 32;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int CRD_W     = 34;
   localparam int DVD_W     = 64;
   localparam int DVS_W     = BASE_W;
   localparam int DCNT_W    = 7;
   localparam int ITER_W    = 5;

   // Parameter defaults
   localparam int DEF_CORDIC_STEPS = 24;
   localparam int DEF_FRAC_BITS    = 16;

   // Arithmetic constants
   localparam logic [20:0] RPM_TO_RADS_Q24 = 21'd1756910;
   localparam logic [25:0] HEAD_SCALE_Q16  = 26'd44798134;
   localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
   localparam logic [31:0] ANGLE_EIGHTH    = 32'h2000_0000;
   localparam logic [19:0] US_PER_SEC      = 20'd1000000;
   // floor(2^50 / 10^6): estimate of a division by one million
   localparam logic [30:0] US_RECIP_Q50    = 31'd1125899906;

   // Configuration port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = BASE_W;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_RADIUS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEEL_BASE   = 8'd1;

   // Quadrant codes of the heading after the eighth-turn offset
   localparam logic [1:0] QUAD_FWD   = 2'd0;
   localparam logic [1:0] QUAD_LEFT  = 2'd1;
   localparam logic [1:0] QUAD_BACK  = 2'd2;
   localparam logic [1:0] QUAD_RIGHT = 2'd3;

   typedef struct packed {
      logic [RPM_W-1:0] left_rpm;
      logic [RPM_W-1:0] right_rpm;
      logic [US_W-1:0]  elapsed_us;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic [DATA_W-1:0]        heading;
      logic signed [DATA_W-1:0] linear_speed;
      logic signed [DATA_W-1:0] turn_rate;
   } rsp_type;

   // Divider request and status
   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
      logic [DCNT_W-1:0] count;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_WL_A,
      S_WL_B,
      S_WR_A,
      S_WR_B,
      S_DIFF,
      S_SPLIT,
      S_DIST_MUL,
      S_DIST_RCP,
      S_DIST_EST,
      S_DIST_BACK,
      S_DIST_FIX,
      S_OMG_START,
      S_OMG_WAIT,
      S_CORDIC,
      S_ROTATE,
      S_X_MUL,
      S_Y_MUL,
      S_H_MUL1,
      S_H_MUL2,
      S_H_MUL3,
      S_H_SUM,
      S_H_START,
      S_H_WAIT,
      S_OUT
   } state_type;

   // Arctangent of 2^-i as a binary angle
   function automatic logic [31:0] atan_bam(input logic [ITER_W-1:0] idx);
      logic [31:0] a;
      case (idx)
         5'd0:  a = 32'h2000_0000;
         5'd1:  a = 32'h12E4_051E;
         5'd2:  a = 32'h09FB_385B;
         5'd3:  a = 32'h0511_11D4;
         5'd4:  a = 32'h028B_0D43;
         5'd5:  a = 32'h0145_D7E1;
         5'd6:  a = 32'h00A2_F61E;
         5'd7:  a = 32'h0051_7C55;
         5'd8:  a = 32'h0028_BE53;
         5'd9:  a = 32'h0014_5F2F;
         5'd10: a = 32'h000A_2F98;
         5'd11: a = 32'h0005_17CC;
         5'd12: a = 32'h0002_8BE6;
         5'd13: a = 32'h0001_45F3;
         5'd14: a = 32'h0000_A2FA;
         5'd15: a = 32'h0000_517D;
         5'd16: a = 32'h0000_28BE;
         5'd17: a = 32'h0000_145F;
         5'd18: a = 32'h0000_0A30;
         5'd19: a = 32'h0000_0518;
         5'd20: a = 32'h0000_028C;
         5'd21: a = 32'h0000_0146;
         5'd22: a = 32'h0000_00A3;
         5'd23: a = 32'h0000_0051;
         5'd24: a = 32'h0000_0029;
         5'd25: a = 32'h0000_0014;
         5'd26: a = 32'h0000_000A;
         5'd27: a = 32'h0000_0005;
         5'd28: a = 32'h0000_0003;
         5'd29: a = 32'h0000_0001;
         5'd30: a = 32'h0000_0001;
         default: a = 32'h0000_0000;
      endcase
      return a;
   endfunction

endpackage

@@ hdl/ddo_div.sv @@
// Restoring long divider, one quotient bit per cycle, shared by the sequencer.
// Dividend arrives top-aligned with the number of quotient bits to produce.
// Depends on ddo_pkg.
module ddo_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ddo_pkg::div_req_type div_req,
   output ddo_pkg::div_rsp_type div_rsp
);

   logic [ddo_pkg::DVD_W-1:0]  dvd_ff, dvd_in;
   logic [ddo_pkg::DVS_W-1:0]  dvs_ff, dvs_in;
   logic [ddo_pkg::DVS_W-1:0]  rem_ff, rem_in;
   logic [ddo_pkg::DVD_W-1:0]  quo_ff, quo_in;
   logic [ddo_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [ddo_pkg::DVS_W:0]    trial;
   logic                       fits;

   // One restoring step per cycle
   always_comb begin
      trial   = {rem_ff, dvd_ff[ddo_pkg::DVD_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         dvd_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = div_req.count;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? ddo_pkg::DVS_W'(trial - {1'b0, dvs_ff})
                       : ddo_pkg::DVS_W'(trial);
         quo_in = {quo_ff[ddo_pkg::DVD_W-2:0], fits};
         dvd_in = {dvd_ff[ddo_pkg::DVD_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ddo_pkg::DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ hdl/differential_drive_odometry.sv @@
// Differential drive dead-reckoning odometry: sequencer, shared multiplier,
// CORDIC rotator and pose accumulators. Depends on ddo_pkg and ddo_div.
//
// Usage:
//   req_ channel carries one tick (left_rpm, right_rpm, elapsed_us); it is
//   taken when req_valid is high and req_stall low. The block raises
//   req_stall for the whole of a tick's processing.
//   rsp_ channel returns one pose per tick (pos_x, pos_y, heading,
//   linear_speed, turn_rate) from an output register; it is taken when
//   rsp_valid is high and rsp_stall low.
//   csr_ writes wheel_radius (index 0) and wheel_base (index 1); other
//   indexes are ignored. The user must write them only while idle; the
//   block itself does not enforce it.
// Work per tick: the shared divider takes most of a tick's time
//   (32+FRAC_BITS and 58 quotient bits, one bit a cycle), beside
//   CORDIC_STEPS rotation steps and a dozen multiply steps on the one
//   shared 36x32 multiplier.
// A finished pose waits in the output register while the next tick is taken;
//   if the receiver still stalls when the following pose is ready, the
//   sequencer holds it until the register frees.
// Reset clears the pose to the origin facing forward and sets both wheel
//   registers to 0.5 m.
module differential_drive_odometry #(
   parameter int CORDIC_STEPS = ddo_pkg::DEF_CORDIC_STEPS,
   parameter int FRAC_BITS    = ddo_pkg::DEF_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ddo_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ddo_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [ddo_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ddo_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int W = ddo_pkg::DATA_W;
   localparam logic [ddo_pkg::RADIUS_W-1:0] RADIUS_RESET =
      ddo_pkg::RADIUS_W'(1) << (FRAC_BITS - 1);
   localparam logic [ddo_pkg::BASE_W-1:0] BASE_RESET =
      ddo_pkg::BASE_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [W-1:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [W-1:0] S32_MIN = 32'sh8000_0000;

   function automatic logic signed [W-1:0] sat32(input logic signed [ddo_pkg::CRD_W-1:0] v);
      logic signed [W-1:0] r;
      if ((v[ddo_pkg::CRD_W-1:W-1] == '0) || (v[ddo_pkg::CRD_W-1:W-1] == '1)) begin
         r = v[W-1:0];
      end else begin
         r = v[ddo_pkg::CRD_W-1] ? S32_MIN : S32_MAX;
      end
      return r;
   endfunction

   ddo_pkg::state_type state_ff, state_in;
   ddo_pkg::req_type   req_ff, req_in;
   logic [ddo_pkg::RADIUS_W-1:0] radius_ff, radius_in;
   logic [ddo_pkg::BASE_W-1:0]   base_ff, base_in;
   logic [ddo_pkg::BASE_W-1:0]   base_eff;

   logic signed [ddo_pkg::PROD_W-1:0] p_ff, p_in;
   logic [W-1:0]  vl_ff, vl_in, vr_ff, vr_in;
   logic [W-1:0]  center_ff, center_in, mag_ff, mag_in;
   logic          neg_ff, neg_in;
   logic [47:0]   num_ff, num_in;
   logic [28:0]   dist_ff, dist_in;
   logic signed [W-1:0] omega_ff, omega_in;
   logic signed [ddo_pkg::CRD_W-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [ddo_pkg::CRD_W-1:0] cs_ff, cs_in, sn_ff, sn_in;
   logic [1:0]    quad_ff, quad_in;
   logic [ddo_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic [23:0]   mu_ff, mu_in;
   logic [49:0]   acc_ff, acc_in;
   logic [57:0]   hd_ff, hd_in;
   logic signed [W-1:0] x_ff, x_in, y_ff, y_in;
   logic [W-1:0]  head_ff, head_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ddo_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic signed [ddo_pkg::MUL_A_W-1:0] mul_a;
   logic signed [ddo_pkg::MUL_B_W-1:0] mul_b;
   logic signed [ddo_pkg::PROD_W-1:0]  mul_p;
   logic [56:0]   wsum;
   logic [W:0]    vsum;
   logic signed [ddo_pkg::CRD_W-1:0] step, xs, ys, atan_ext;
   logic [W-1:0]  shifted;
   logic [49:0]   hsum;
   logic [47:0]   dist_rem;

   ddo_pkg::div_req_type div_req;
   ddo_pkg::div_rsp_type div_rsp;

   ddo_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign base_eff = (base_ff == '0) ? ddo_pkg::BASE_W'(1) : base_ff;

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ddo_pkg::S_WL_A: begin
            mul_a = ddo_pkg::MUL_A_W'(req_ff.left_rpm);
            mul_b = ddo_pkg::MUL_B_W'(radius_ff);
         end
         ddo_pkg::S_WR_A: begin
            mul_a = ddo_pkg::MUL_A_W'(req_ff.right_rpm);
            mul_b = ddo_pkg::MUL_B_W'(radius_ff);
         end
         ddo_pkg::S_WL_B, ddo_pkg::S_WR_B: begin
            mul_a = ddo_pkg::MUL_A_W'(p_ff[34:0]);
            mul_b = ddo_pkg::MUL_B_W'(ddo_pkg::RPM_TO_RADS_Q24);
         end
         ddo_pkg::S_DIST_MUL: begin
            mul_a = ddo_pkg::MUL_A_W'(center_ff);
            mul_b = ddo_pkg::MUL_B_W'(req_ff.elapsed_us);
         end
         ddo_pkg::S_DIST_RCP: begin
            mul_a = ddo_pkg::MUL_A_W'(p_ff[47:16]);
            mul_b = ddo_pkg::MUL_B_W'(ddo_pkg::US_RECIP_Q50);
         end
         ddo_pkg::S_DIST_BACK: begin
            mul_a = ddo_pkg::MUL_A_W'(dist_ff);
            mul_b = ddo_pkg::MUL_B_W'(ddo_pkg::US_PER_SEC);
         end
         ddo_pkg::S_X_MUL: begin
            mul_a = ddo_pkg::MUL_A_W'(cs_ff);
            mul_b = ddo_pkg::MUL_B_W'(dist_ff);
         end
         ddo_pkg::S_Y_MUL: begin
            mul_a = ddo_pkg::MUL_A_W'(sn_ff);
            mul_b = ddo_pkg::MUL_B_W'(dist_ff);
         end
         ddo_pkg::S_H_MUL1: begin
            mul_a = ddo_pkg::MUL_A_W'(mag_ff);
            mul_b = ddo_pkg::MUL_B_W'(req_ff.elapsed_us);
         end
         ddo_pkg::S_H_MUL2: begin
            mul_a = ddo_pkg::MUL_A_W'(p_ff[23:0]);
            mul_b = ddo_pkg::MUL_B_W'(ddo_pkg::HEAD_SCALE_Q16);
         end
         ddo_pkg::S_H_MUL3: begin
            mul_a = ddo_pkg::MUL_A_W'(mu_ff);
            mul_b = ddo_pkg::MUL_B_W'(ddo_pkg::HEAD_SCALE_Q16);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = ddo_pkg::PROD_W'(mul_a) * ddo_pkg::PROD_W'(mul_b);

   // Helpers read by several states
   always_comb begin
      wsum     = {1'b0, p_ff[55:0]} + (57'd1 << 23);
      vsum     = {1'b0, vl_ff} + {1'b0, vr_ff};
      step     = p_ff[63:30];
      xs       = cx_ff >>> iter_ff;
      ys       = cy_ff >>> iter_ff;
      atan_ext = ddo_pkg::CRD_W'(ddo_pkg::atan_bam(iter_ff));
      shifted  = head_ff + ddo_pkg::ANGLE_EIGHTH;
      hsum     = 50'(acc_ff[49:24]) + p_ff[49:0];
      dist_rem = num_ff - p_ff[47:0];
   end

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      radius_in    = radius_ff;
      base_in      = base_ff;
      p_in         = p_ff;
      vl_in        = vl_ff;
      vr_in        = vr_ff;
      center_in    = center_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      num_in       = num_ff;
      dist_in      = dist_ff;
      omega_in     = omega_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      cs_in        = cs_ff;
      sn_in        = sn_ff;
      quad_in      = quad_ff;
      iter_in      = iter_ff;
      mu_in        = mu_ff;
      acc_in       = acc_ff;
      hd_in        = hd_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      head_in      = head_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_req      = '0;

      // Register writes
      if (csr_we) begin
         if (csr_index == ddo_pkg::CSR_WHEEL_RADIUS) begin
            radius_in = csr_wdata[ddo_pkg::RADIUS_W-1:0];
         end else if (csr_index == ddo_pkg::CSR_WHEEL_BASE) begin
            base_in = csr_wdata[ddo_pkg::BASE_W-1:0];
         end
      end

      case (state_ff)
         ddo_pkg::S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ddo_pkg::S_WL_A;
            end
         end
         ddo_pkg::S_WL_A: begin
            p_in     = mul_p;
            state_in = ddo_pkg::S_WL_B;
         end
         ddo_pkg::S_WL_B: begin
            p_in     = mul_p;
            state_in = ddo_pkg::S_WR_A;
         end
         ddo_pkg::S_WR_A: begin
            vl_in    = wsum[55:24];
            p_in     = mul_p;
            state_in = ddo_pkg::S_WR_B;
         end
         ddo_pkg::S_WR_B: begin
            p_in     = mul_p;
            state_in = ddo_pkg::S_DIFF;
         end
         ddo_pkg::S_DIFF: begin
            vr_in    = wsum[55:24];
            state_in = ddo_pkg::S_SPLIT;
         end
         ddo_pkg::S_SPLIT: begin
            // Centre speed, direction and magnitude of the wheel difference
            center_in = vsum[W:1];
            neg_in    = vr_ff < vl_ff;
            mag_in    = (vr_ff < vl_ff) ? (vl_ff - vr_ff) : (vr_ff - vl_ff);
            state_in  = ddo_pkg::S_DIST_MUL;
         end
         ddo_pkg::S_DIST_MUL: begin
            p_in     = mul_p;
            state_in = ddo_pkg::S_DIST_RCP;
         end
         ddo_pkg::S_DIST_RCP: begin
            // Keep the product and estimate it over one million
            num_in   = p_ff[47:0];
            p_in     = mul_p;
            state_in = ddo_pkg::S_DIST_EST;
         end
         ddo_pkg::S_DIST_EST: begin
            // Estimate is exact or one short
            dist_in  = p_ff[62:34];
            state_in = ddo_pkg::S_DIST_BACK;
         end
         ddo_pkg::S_DIST_BACK: begin
            p_in     = mul_p;
            state_in = ddo_pkg::S_DIST_FIX;
         end
         ddo_pkg::S_DIST_FIX: begin
            // Bump the estimate when a whole million is left over
            if (dist_rem >= 48'(ddo_pkg::US_PER_SEC)) begin
               dist_in = dist_ff + 29'd1;
            end
            state_in = ddo_pkg::S_OMG_START;
         end
         ddo_pkg::S_OMG_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = {mag_ff, 32'd0};
            div_req.divisor  = base_eff;
            div_req.count    = ddo_pkg::DCNT_W'(W + FRAC_BITS);
            state_in         = ddo_pkg::S_OMG_WAIT;
         end
         ddo_pkg::S_OMG_WAIT: begin
            if (div_rsp.done) begin
               // Sign and saturate the turn rate
               if (div_rsp.quotient[ddo_pkg::DVD_W-1:W-1] != '0) begin
                  omega_in = neg_ff ? S32_MIN : S32_MAX;
               end else begin
                  omega_in = neg_ff ? -$signed(div_rsp.quotient[W-1:0])
                                    : $signed(div_rsp.quotient[W-1:0]);
               end
               // Load the rotator with the heading held before this tick
               quad_in  = shifted[31:30];
               cz_in    = ddo_pkg::CRD_W'(shifted[29:0]) -
                          ddo_pkg::CRD_W'(ddo_pkg::ANGLE_EIGHTH);
               cx_in    = ddo_pkg::CRD_W'(ddo_pkg::CORDIC_GAIN_Q30);
               cy_in    = '0;
               iter_in  = '0;
               state_in = ddo_pkg::S_CORDIC;
            end
         end
         ddo_pkg::S_CORDIC: begin
            if (!cz_ff[ddo_pkg::CRD_W-1]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - atan_ext;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + atan_ext;
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ddo_pkg::ITER_W'(CORDIC_STEPS - 1)) begin
               state_in = ddo_pkg::S_ROTATE;
            end
         end
         ddo_pkg::S_ROTATE: begin
            case (quad_ff)
               ddo_pkg::QUAD_FWD: begin
                  cs_in = cx_ff;
                  sn_in = cy_ff;
               end
               ddo_pkg::QUAD_LEFT: begin
                  cs_in = -cy_ff;
                  sn_in = cx_ff;
               end
               ddo_pkg::QUAD_BACK: begin
                  cs_in = -cx_ff;
                  sn_in = -cy_ff;
               end
               default: begin
                  cs_in = cy_ff;
                  sn_in = -cx_ff;
               end
            endcase
            state_in = ddo_pkg::S_X_MUL;
         end
         ddo_pkg::S_X_MUL: begin
            p_in     = mul_p;
            state_in = ddo_pkg::S_Y_MUL;
         end
         ddo_pkg::S_Y_MUL: begin
            x_in     = sat32(ddo_pkg::CRD_W'(x_ff) + step);
            p_in     = mul_p;
            state_in = ddo_pkg::S_H_MUL1;
         end
         ddo_pkg::S_H_MUL1: begin
            y_in     = sat32(ddo_pkg::CRD_W'(y_ff) + step);
            p_in     = mul_p;
            state_in = ddo_pkg::S_H_MUL2;
         end
         ddo_pkg::S_H_MUL2: begin
            mu_in    = p_ff[47:24];
            p_in     = mul_p;
            state_in = ddo_pkg::S_H_MUL3;
         end
         ddo_pkg::S_H_MUL3: begin
            acc_in   = p_ff[49:0];
            p_in     = mul_p;
            state_in = ddo_pkg::S_H_SUM;
         end
         ddo_pkg::S_H_SUM: begin
            // Combine partial products, drop the low 16 bits of the scale
            hd_in    = {hsum, acc_ff[23:16]};
            state_in = ddo_pkg::S_H_START;
         end
         ddo_pkg::S_H_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = {hd_ff, 6'd0};
            div_req.divisor  = base_eff;
            div_req.count    = ddo_pkg::DCNT_W'(58);
            state_in         = ddo_pkg::S_H_WAIT;
         end
         ddo_pkg::S_H_WAIT: begin
            if (div_rsp.done) begin
               head_in  = neg_ff ? (head_ff - div_rsp.quotient[W-1:0])
                                 : (head_ff + div_rsp.quotient[W-1:0]);
               state_in = ddo_pkg::S_OUT;
            end
         end
         ddo_pkg::S_OUT: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.pos_x        = x_ff;
               rsp_data_in.pos_y        = y_ff;
               rsp_data_in.heading      = head_ff;
               rsp_data_in.linear_speed = center_ff[W-1] ? S32_MAX : $signed(center_ff);
               rsp_data_in.turn_rate    = omega_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = ddo_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ddo_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ddo_pkg::S_IDLE;
         radius_ff    <= RADIUS_RESET;
         base_ff      <= BASE_RESET;
         x_ff         <= '0;
         y_ff         <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         base_ff      <= base_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         iter_ff      <= iter_in;
      end
      req_ff      <= req_in;
      p_ff        <= p_in;
      vl_ff       <= vl_in;
      vr_ff       <= vr_in;
      center_ff   <= center_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      num_ff      <= num_in;
      dist_ff     <= dist_in;
      omega_ff    <= omega_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      cs_ff       <= cs_in;
      sn_ff       <= sn_in;
      quad_ff     <= quad_in;
      mu_ff       <= mu_in;
      acc_ff      <= acc_in;
      hd_ff       <= hd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ddo_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A taken transaction blocks the input until its pose is built
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not blocked after a transaction");

   // The divider only runs while the sequencer waits on it
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_rsp.busy |-> (state_ff == ddo_pkg::S_OMG_WAIT ||
                        state_ff == ddo_pkg::S_H_WAIT))
      else $error("divider busy outside a wait state");

   // Rotation count never passes the configured number of steps
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ddo_pkg::S_CORDIC) |-> (iter_ff <= ddo_pkg::ITER_W'(CORDIC_STEPS - 1)))
      else $error("CORDIC step count overrun");

   // A new pose is only loaded into a free or draining output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ddo_pkg::S_OUT) && rsp_valid_ff && rsp_stall |=> rsp_valid_ff &&
      $stable(rsp_data_ff))
      else $error("pending pose overwritten");

endmodule
